@@ design/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 12;
	localparam int OFFSET_BITS_DEF  = 16;

	localparam int SIZE_W  = 16;
	localparam int LIMIT_W = 17;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	typedef enum logic [2:0] {
		STS_OK,
		STS_NULL,
		STS_NOMEM,
		STS_FULL,
		STS_NOTFOUND
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_MERGE
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_DECIDE,
		S_MERGE_R,
		S_MERGE_L,
		S_DONE
	} state_t;

	// search token flags handed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
		logic last_free;
		logic prev_free;
		logic next_free;
	} tok_flags_t;

endpackage

@@ design/ffa_req_if.sv @@
// ----------------------------------------------------------------------------
// ffa_req_if
// request channel: operation, size and offset
// ----------------------------------------------------------------------------
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] request_size;
	logic [15:0] free_offset;

	modport source (output valid, output func, output request_size, output free_offset,
		input ready);
	modport sink (input valid, input func, input request_size, input free_offset,
		output ready);
endinterface

@@ design/ffa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ffa_rsp_if
// response channel: data offset and status
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_offset;
	logic [2:0]  status;

	modport source (output valid, output data_offset, output status, input ready);
	modport sink (input valid, input data_offset, input status, output ready);
endinterface

@@ design/ffa_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ffa_cfg_if
// configuration write channel for the heap limit
// ----------------------------------------------------------------------------
interface ffa_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/ffa_cell.sv @@
// ----------------------------------------------------------------------------
// ffa_cell
// one table entry of the allocator chain with its slice of the search token
// ----------------------------------------------------------------------------
module ffa_cell #(
	parameter int IDX          = 0,
	parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int OFFSET_BITS  = ffa_pkg::OFFSET_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_BLOCKS),
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ffa_pkg::cell_op_t      cmd_op,
	input  logic [IDX_W-1:0]       cmd_idx,
	input  logic [CNT_W-1:0]       count,
	input  logic                   func,
	input  logic [15:0]            req_size,
	input  logic [15:0]            free_off,
	input  logic [OFFSET_BITS-1:0] w_start,
	input  logic [OFFSET_BITS-1:0] w_size,
	input  logic [OFFSET_BITS-1:0] r_start,
	input  logic [OFFSET_BITS-1:0] r_size,
	input  logic                   r_free,
	output logic [OFFSET_BITS-1:0] start,
	output logic [OFFSET_BITS-1:0] size,
	output logic                   free,
	input  ffa_pkg::tok_flags_t    tin,
	input  logic [IDX_W-1:0]       tin_idx,
	input  logic [OFFSET_BITS-1:0] tin_start,
	output ffa_pkg::tok_flags_t    tout,
	output logic [IDX_W-1:0]       tout_idx,
	output logic [OFFSET_BITS-1:0] tout_start
);

	localparam int CW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
	localparam int SW = (OFFSET_BITS + 1 > 16) ? OFFSET_BITS + 1 : 16;

	logic [OFFSET_BITS-1:0] start_q, size_q;
	logic                   free_q;
	ffa_pkg::tok_flags_t    tok_q;
	ffa_pkg::tok_flags_t    tok_d;
	logic [IDX_W-1:0]       tok_idx_q;
	logic [OFFSET_BITS-1:0] tok_start_q;

	logic                   live, fit, hit, match, after_hit;
	logic [SW-1:0]          data_off;

	assign live      = CNT_W'(IDX) < count;
	assign fit       = free_q && (CW'(size_q) >= CW'(req_size));
	assign data_off  = SW'(start_q) + SW'(HEADER_BYTES);
	assign hit       = data_off == SW'(free_off);
	assign match     = live && ((func == ffa_pkg::FN_FREE) ? hit : fit);
	assign after_hit = (IDX != 0) && (tin_idx == IDX_W'(IDX - 1));

	// table entry
	always_ff @(posedge clk) begin
		if (cmd_op == ffa_pkg::CMD_WRITE && cmd_idx == IDX_W'(IDX)) begin
			start_q <= w_start;
			size_q  <= w_size;
			free_q  <= 1'b0;
		end else if (cmd_op == ffa_pkg::CMD_MERGE && cmd_idx == IDX_W'(IDX)) begin
			size_q <= size_q + OFFSET_BITS'(HEADER_BYTES) + r_size;
		end else if (cmd_op == ffa_pkg::CMD_MERGE && cmd_idx < IDX_W'(IDX)) begin
			start_q <= r_start;
			size_q  <= r_size;
			free_q  <= r_free;
		end else if (tin.valid && !tin.found && match) begin
			free_q <= (func == ffa_pkg::FN_FREE);
		end
	end

	// next token flags
	always_comb begin
		tok_d           = tin;
		tok_d.last_free = live && free_q;
		if (tin.valid && !tin.found && match) begin
			tok_d.found     = 1'b1;
			tok_d.prev_free = tin.last_free;
		end else if (tin.valid && tin.found && after_hit) begin
			tok_d.next_free = live && free_q;
		end
	end

	// token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (tin.valid && !tin.found && match) begin
			tok_idx_q   <= IDX_W'(IDX);
			tok_start_q <= start_q;
		end else begin
			tok_idx_q   <= tin_idx;
			tok_start_q <= tin_start;
		end
	end

	assign start      = start_q;
	assign size       = size_q;
	assign free       = free_q;
	assign tout       = tok_q;
	assign tout_idx   = tok_idx_q;
	assign tout_start = tok_start_q;

endmodule

@@ design/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap block table with coalescing of free neighbours
// ----------------------------------------------------------------------------
//  channel  dir  transaction
//  req      in   func, request_size, free_offset
//  rsp      out  data_offset, status
//  cfg      in   heap limit write (data)
//
//  an allocate passes the start, scan, decide and done states; a free that finds
//  its block also merges right, then left; the search token walks the cell chain
//  one cell a cycle, and a zero size or null offset is answered without a search
//  arst_n clears the control state and sets the heap limit to 65536
//  a stalled rsp holds the result; the next request is taken while it waits,
//  and its result waits in the done state until the output register is free
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int OFFSET_BITS  = ffa_pkg::OFFSET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ffa_req_if.sink   req,
	ffa_rsp_if.source rsp,
	ffa_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int OB    = OFFSET_BITS;
	// wide enough for break + header + request
	localparam int NB_W  = ((OB + 1 > 17) ? OB + 1 : 17) + 1;
	localparam int SW    = (OB + 1 > 16) ? OB + 1 : 16;

	ffa_pkg::state_t state_q, state_d;

	// latched request
	logic        func_q;
	logic [15:0] size_q;
	logic [15:0] off_q;

	// heap bookkeeping
	logic [CNT_W-1:0]   count_q;
	logic [OB:0]        brk_q;
	logic [16:0]        limit_q;

	// search result
	logic              found_q, prev_free_q, next_free_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [OB-1:0]     hit_start_q;

	// pending result and output register
	logic [15:0]       res_off_q;
	ffa_pkg::status_t  res_st_q;
	logic              out_valid_q;
	logic [15:0]       out_off_q;
	ffa_pkg::status_t  out_st_q;

	// chain wiring
	ffa_pkg::tok_flags_t tok  [MAX_BLOCKS+1];
	logic [IDX_W-1:0]    tidx [MAX_BLOCKS+1];
	logic [OB-1:0]       tst  [MAX_BLOCKS+1];
	logic [OB-1:0]       c_start [MAX_BLOCKS+1];
	logic [OB-1:0]       c_size  [MAX_BLOCKS+1];
	logic                c_free  [MAX_BLOCKS+1];

	ffa_pkg::cell_op_t   cmd_op;
	logic [IDX_W-1:0]    cmd_idx;

	logic                accept, is_null, out_free;
	logic [NB_W-1:0]     new_brk, eff_lim;
	logic [SW-1:0]       hit_data, brk_data;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ffa_pkg::S_IDLE);
	assign cfg.ready = 1'b1;
	assign is_null  = (req.func == ffa_pkg::FN_ALLOC) ? (req.request_size == '0)
		: (req.free_offset == '0);
	assign out_free = !out_valid_q || rsp.ready;

	// break after appending, against the limit saturated at the offset range
	assign new_brk  = NB_W'(brk_q) + NB_W'(HEADER_BYTES) + NB_W'(size_q);
	assign eff_lim  = (NB_W'(limit_q) > (NB_W'(1) << OB)) ? (NB_W'(1) << OB)
		: NB_W'(limit_q);
	assign hit_data = SW'(hit_start_q) + SW'(HEADER_BYTES);
	assign brk_data = SW'(brk_q) + SW'(HEADER_BYTES);

	// injected token and the dummy right neighbour of the last cell
	assign tok[0]             = '{valid: (state_q == ffa_pkg::S_START), default: 1'b0};
	assign tidx[0]            = '0;
	assign tst[0]             = '0;
	assign c_start[MAX_BLOCKS] = '0;
	assign c_size[MAX_BLOCKS]  = '0;
	assign c_free[MAX_BLOCKS]  = 1'b0;

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		ffa_cell #(
			.IDX          (i),
			.MAX_BLOCKS   (MAX_BLOCKS),
			.HEADER_BYTES (HEADER_BYTES),
			.OFFSET_BITS  (OFFSET_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd_op     (cmd_op),
			.cmd_idx    (cmd_idx),
			.count      (count_q),
			.func       (func_q),
			.req_size   (size_q),
			.free_off   (off_q),
			.w_start    (brk_q[OB-1:0]),
			.w_size     (OB'(size_q)),
			.r_start    (c_start[i+1]),
			.r_size     (c_size[i+1]),
			.r_free     (c_free[i+1]),
			.start      (c_start[i]),
			.size       (c_size[i]),
			.free       (c_free[i]),
			.tin        (tok[i]),
			.tin_idx    (tidx[i]),
			.tin_start  (tst[i]),
			.tout       (tok[i+1]),
			.tout_idx   (tidx[i+1]),
			.tout_start (tst[i+1])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and cell commands
	always_comb begin
		state_d = state_q;
		cmd_op  = ffa_pkg::CMD_NONE;
		cmd_idx = hit_idx_q;
		case (state_q)
			ffa_pkg::S_IDLE: begin
				if (accept) begin
					state_d = is_null ? ffa_pkg::S_DONE : ffa_pkg::S_START;
				end
			end
			ffa_pkg::S_START: begin
				state_d = ffa_pkg::S_SCAN;
			end
			ffa_pkg::S_SCAN: begin
				// token has left the last cell
				if (tok[MAX_BLOCKS].valid) begin
					state_d = ffa_pkg::S_DECIDE;
				end
			end
			ffa_pkg::S_DECIDE: begin
				if (func_q == ffa_pkg::FN_FREE && found_q) begin
					state_d = ffa_pkg::S_MERGE_R;
				end else begin
					state_d = ffa_pkg::S_DONE;
				end
				if (func_q == ffa_pkg::FN_ALLOC && !found_q && new_brk <= eff_lim
						&& count_q != CNT_W'(MAX_BLOCKS)) begin
					cmd_op  = ffa_pkg::CMD_WRITE;
					cmd_idx = count_q[IDX_W-1:0];
				end
			end
			ffa_pkg::S_MERGE_R: begin
				// fold the free right neighbour into the freed block
				state_d = ffa_pkg::S_MERGE_L;
				if (next_free_q) begin
					cmd_op = ffa_pkg::CMD_MERGE;
				end
			end
			ffa_pkg::S_MERGE_L: begin
				// fold the freed block into a free left neighbour
				state_d = ffa_pkg::S_DONE;
				if (prev_free_q) begin
					cmd_op  = ffa_pkg::CMD_MERGE;
					cmd_idx = hit_idx_q - IDX_W'(1);
				end
			end
			ffa_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ffa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffa_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			brk_q       <= '0;
			limit_q     <= ffa_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			if (cmd_op == ffa_pkg::CMD_WRITE) begin
				count_q <= count_q + CNT_W'(1);
				brk_q   <= new_brk[OB:0];
			end else if (cmd_op == ffa_pkg::CMD_MERGE) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (state_q == ffa_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= req.func;
			size_q    <= req.request_size;
			off_q     <= req.free_offset;
			res_off_q <= '0;
			res_st_q  <= ffa_pkg::STS_NULL;
		end
		if (state_q == ffa_pkg::S_SCAN && tok[MAX_BLOCKS].valid) begin
			found_q     <= tok[MAX_BLOCKS].found;
			prev_free_q <= tok[MAX_BLOCKS].prev_free;
			next_free_q <= tok[MAX_BLOCKS].next_free;
			hit_idx_q   <= tidx[MAX_BLOCKS];
			hit_start_q <= tst[MAX_BLOCKS];
		end
		if (state_q == ffa_pkg::S_DECIDE) begin
			if (func_q == ffa_pkg::FN_FREE) begin
				res_st_q  <= found_q ? ffa_pkg::STS_OK : ffa_pkg::STS_NOTFOUND;
				res_off_q <= '0;
			end else if (found_q) begin
				res_st_q  <= ffa_pkg::STS_OK;
				res_off_q <= hit_data[15:0];
			end else if (new_brk > eff_lim) begin
				res_st_q  <= ffa_pkg::STS_NOMEM;
				res_off_q <= '0;
			end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
				res_st_q  <= ffa_pkg::STS_FULL;
				res_off_q <= '0;
			end else begin
				res_st_q  <= ffa_pkg::STS_OK;
				res_off_q <= brk_data[15:0];
			end
		end
		if (state_q == ffa_pkg::S_DONE && out_free) begin
			out_off_q <= res_off_q;
			out_st_q  <= res_st_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data_offset = out_off_q;
	assign rsp.status      = out_st_q;

endmodule
